>>> hdl/nmv_pkg.sv
// Shared types, character codes and helpers for the NMEA sentence validator.
package nmv_pkg;

  localparam int LenW = 7;
  localparam int ByteW = 8;
  localparam int StatW = 3;
  localparam int CfgIdxW = 2;

  localparam logic [LenW-1:0] LenSat = 7'd127;
  localparam logic [LenW-1:0] MinLenRst = 7'd9;
  localparam logic [LenW-1:0] MaxLenRst = 7'd82;

  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChStar = 8'h2A;
  localparam logic [ByteW-1:0] ChNl = 8'h0A;

  localparam logic [CfgIdxW-1:0] RegMinLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxLength = 2'd1;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_LONG      = 3'd2,
    ST_NO_DOLLAR = 3'd3,
    ST_BAD_SUM   = 3'd4
  } status_t;

  // Sentence state after folding in the current byte.
  typedef struct packed {
    logic [LenW-1:0]  byte_count;
    logic [ByteW-1:0] running_xor;
    logic             xor_stopped;
    logic             dollar_ok;
    logic             star_seen;
    logic [1:0]       after_star_count;
    logic [ByteW-1:0] hex_high;
    logic [ByteW-1:0] hex_low;
  } sentence_t;

  // {ok, nibble}; ok is low for anything but 0-9, A-F, a-f.
  function automatic logic [4:0] hex_value(input logic [ByteW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

>>> hdl/nmv_in_if.sv
// Request channel carrying one sentence character per transfer.
interface nmv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

>>> hdl/nmv_out_if.sv
// Result channel carrying one sentence report per transfer.
interface nmv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;

  modport source (output valid, status, computed_sum, received_sum, input ready);
  modport sink (input valid, status, computed_sum, received_sum, output ready);
endinterface

>>> hdl/nmea_sentence_validator.sv
// Top level of the NMEA sentence validator.
//
// Takes an NMEA sentence one character per request on "sentence", with
// last_byte set on its final character, and returns one report per sentence
// on "report": status (ok, too short, too long, no leading '$', checksum
// error), the XOR of the body between '$' and the first '*' or newline, and
// the two hex digits after the last '*'. A missing '*', a short tail or a
// non-hex digit reads as a checksum error with received_sum of zero. Length
// counts saturate at 127. Throughput is one character per clock unless a
// report waits untaken in the single output register, loaded from the
// final character; meanwhile the input stalls, so a slow report consumer
// throttles the character stream. min_length and max_length (reset 9 and
// 82) are written through cfg_we/cfg_index/cfg_data; the user must do so
// only with no sentence in flight, unenforced; other indexes are ignored.
module nmea_sentence_validator (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [nmv_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [nmv_pkg::LenW-1:0] cfg_data,
  nmv_in_if.sink                   sentence,
  nmv_out_if.source                report
);
  import nmv_pkg::*;

  logic [LenW-1:0] min_length;
  logic [LenW-1:0] max_length;

  logic      accept;
  logic      finish;
  sentence_t snap;

  logic [4:0]       hi_dec;
  logic [4:0]       lo_dec;
  logic             sum_present;
  logic [ByteW-1:0] recv;
  status_t          status_next;

  // output register drains or is empty -> room for the next character
  assign sentence.ready = !report.valid || report.ready;
  assign accept = sentence.valid && sentence.ready;
  assign finish = accept && sentence.last_byte;

  nmv_track u_track (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (sentence.data_byte),
    .last_byte (sentence.last_byte),
    .snap      (snap)
  );

  // checksum decode; valid only with both digits captured after a '*'
  assign hi_dec = hex_value(snap.hex_high);
  assign lo_dec = hex_value(snap.hex_low);
  assign sum_present = snap.star_seen && (snap.after_star_count == 2'd2)
                       && hi_dec[4] && lo_dec[4];
  assign recv = sum_present ? {hi_dec[3:0], lo_dec[3:0]} : '0;

  // first failing test wins
  always_comb begin
    if (snap.byte_count < min_length) begin
      status_next = ST_SHORT;
    end else if (snap.byte_count > max_length) begin
      status_next = ST_LONG;
    end else if (!snap.dollar_ok) begin
      status_next = ST_NO_DOLLAR;
    end else if (!sum_present || recv != snap.running_xor) begin
      status_next = ST_BAD_SUM;
    end else begin
      status_next = ST_OK;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MinLenRst;
      max_length <= MaxLenRst;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMinLength: min_length <= cfg_data;
        RegMaxLength: max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (finish) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      report.status       <= status_next;
      report.computed_sum <= snap.running_xor;
      report.received_sum <= recv;
    end
  end

  // a finished sentence always shows up as a report next cycle
  a_report_follows: assert property (@(posedge clk) disable iff (rst)
    finish |=> report.valid)
    else $error("report missing after final character");

  // a new report only ever comes from a final character
  a_report_source: assert property (@(posedge clk) disable iff (rst)
    $rose(report.valid) |-> $past(finish))
    else $error("report without a final character");

  // ok status means the checksums agree
  a_ok_matches: assert property (@(posedge clk) disable iff (rst)
    report.valid && report.status == ST_OK |-> report.computed_sum == report.received_sum)
    else $error("ok status with mismatched checksum");

  // no character accepted while an untaken report is held
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    report.valid && !report.ready |-> !accept)
    else $error("character taken while report stalled");
endmodule

>>> hdl/nmv_track.sv
// Per-sentence tracking: length, leading dollar, running XOR, checksum capture.
module nmv_track (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output nmv_pkg::sentence_t      snap
);
  import nmv_pkg::*;

  sentence_t cur;
  sentence_t cur_next;

  always_comb begin
    cur_next = cur;
    if (cur.byte_count != LenSat) begin
      cur_next.byte_count = cur.byte_count + 7'd1;
    end
    if (cur.byte_count == '0) begin
      cur_next.dollar_ok = (data_byte == ChDollar);
    end else if (!cur.xor_stopped) begin
      if (data_byte == ChStar || data_byte == ChNl) begin
        cur_next.xor_stopped = 1'b1;
      end else begin
        cur_next.running_xor = cur.running_xor ^ data_byte;
      end
    end
    if (data_byte == ChStar) begin
      cur_next.star_seen = 1'b1;
      cur_next.after_star_count = 2'd0;
    end else if (cur.star_seen && cur.after_star_count != 2'd2) begin
      if (cur.after_star_count == 2'd0) begin
        cur_next.hex_high = data_byte;
      end else begin
        cur_next.hex_low = data_byte;
      end
      cur_next.after_star_count = cur.after_star_count + 2'd1;
    end
  end

  assign snap = cur_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (accept) begin
      cur <= last_byte ? sentence_t'('0) : cur_next;
    end
  end

  // a byte that does not end the sentence leaves a nonzero count
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    accept && !last_byte |=> cur.byte_count != '0)
    else $error("byte count did not advance");

  // ending a sentence clears all tracking state
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> cur == '0)
    else $error("sentence state not cleared");

  // capture counter never runs past the two checksum digits
  a_capture_bound: assert property (@(posedge clk) disable iff (rst)
    cur.after_star_count != 2'd3)
    else $error("checksum capture overran");
endmodule

>>> bench/tb_nmea_sentence_validator.sv
// Self-checking bench for the NMEA sentence validator: predicted reports vs. the block's own.
`timescale 1ns / 1ps

module tb_nmea_sentence_validator;
  import nmv_pkg::*;

  // Value that marks a byte as no hex digit.
  localparam int HexRadix = 16;
  // Index that maps to no register; a write to it must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd2;
  localparam int Phases = 9;

  // One character request, with its end-of-sentence flag.
  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             is_last;
  } char_req_t;

  // One sentence report as the block should return it.
  typedef struct {
    status_t          status;
    logic [ByteW-1:0] computed_sum;
    logic [ByteW-1:0] received_sum;
  } sentence_report_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [LenW-1:0]     cfg_data;

  nmv_in_if  char_if ();
  nmv_out_if report_if ();

  nmea_sentence_validator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sentence  (char_if),
    .report    (report_if)
  );

  // Character requests waiting for the driver, and reports still owed by the block.
  char_req_t        char_q[$];
  sentence_report_t report_q[$];
  // Scratch line that the stimulus code builds a sentence in before queuing it.
  logic [ByteW-1:0] line_buf[$];

  // Predictor copy of the registers and of the per-sentence state.
  logic [LenW-1:0]  cfg_min_len;
  logic [LenW-1:0]  cfg_max_len;
  logic [LenW-1:0]  len_cnt;
  logic [ByteW-1:0] body_xor;
  logic             body_closed;
  logic             lead_dollar;
  logic             star_open;
  logic [1:0]       digits_got;
  logic [ByteW-1:0] digit_hi;
  logic [ByteW-1:0] digit_lo;

  int               fail_count;
  int               bytes_sent;
  int               in_gap;
  int               out_gap;
  bit               in_calm;
  bit               out_calm;
  char_req_t        cur_req;
  sentence_report_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int hex_digit(input logic [ByteW-1:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return HexRadix;
  endfunction

  // ASCII hex for one nibble; 8'h37 / 8'h57 are 'A' / 'a' minus ten.
  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 10) return 8'h30 + v;
    return lower ? 8'h57 + v : 8'h37 + v;
  endfunction

  // Body filler: mostly printable, now and then any byte, never '*' or newline.
  function automatic logic [ByteW-1:0] body_char();
    logic [ByteW-1:0] c;
    c = ChStar;
    while (c == ChStar || c == ChNl) begin
      if ($urandom_range(0, 9) == 0) c = 8'($urandom);
      else c = 8'($urandom_range(32, 126));
    end
    return c;
  endfunction

  // Predictor: folds one accepted character into the sentence state and, on the
  // final character, queues the report the block owes for the sentence.
  task automatic fold_char(input logic [ByteW-1:0] c, input logic is_last);
    logic             opening;
    int               hv;
    int               lv;
    logic [ByteW-1:0] got;
    logic             match;
    sentence_report_t r;
    opening = (len_cnt == 0);
    if (len_cnt != LenSat) len_cnt++;
    // First byte only decides the '$' test; the XOR covers the rest up to
    // the first '*' or newline and then freezes for the sentence.
    if (opening) begin
      lead_dollar = (c == ChDollar);
    end else if (!body_closed) begin
      if (c == ChStar || c == ChNl) body_closed = 1'b1;
      else body_xor ^= c;
    end
    // Every '*' restarts the digit capture, so the last one wins.
    if (c == ChStar) begin
      star_open = 1'b1;
      digits_got = 2'd0;
    end else if (star_open && digits_got < 2) begin
      if (digits_got == 0) digit_hi = c;
      else digit_lo = c;
      digits_got++;
    end
    if (is_last) begin
      got = '0;
      match = 1'b0;
      if (star_open && digits_got == 2) begin
        hv = hex_digit(digit_hi);
        lv = hex_digit(digit_lo);
        if (hv < HexRadix && lv < HexRadix) begin
          got = 8'(hv * HexRadix + lv);
          match = (got == body_xor);
        end
      end
      // First failing test wins: short, long, no '$', bad checksum.
      if (len_cnt < cfg_min_len) r.status = ST_SHORT;
      else if (len_cnt > cfg_max_len) r.status = ST_LONG;
      else if (!lead_dollar) r.status = ST_NO_DOLLAR;
      else if (!match) r.status = ST_BAD_SUM;
      else r.status = ST_OK;
      r.computed_sum = body_xor;
      r.received_sum = got;
      report_q.insert(report_q.size(), r);
      len_cnt = '0;
      body_xor = '0;
      body_closed = 1'b0;
      lead_dollar = 1'b0;
      star_open = 1'b0;
      digits_got = 2'd0;
      digit_hi = '0;
      digit_lo = '0;
    end
  endtask

  // Register write; only called with nothing in flight, so the predictor copy
  // can follow at once.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LenW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == RegMinLength) cfg_min_len = val;
    else if (idx == RegMaxLength) cfg_max_len = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the sender until every report is back, then lets the block settle.
  task automatic wait_idle();
    while (char_q.size() != 0 || char_if.valid || report_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.insert(line_buf.size(), s[i]);
  endtask

  // Moves the scratch line to the driver queue, flagging its final byte.
  task automatic queue_line();
    for (int i = 0; i < line_buf.size(); i++)
      char_q.insert(char_q.size(), {line_buf[i], 1'(i == line_buf.size() - 1)});
    bytes_sent += line_buf.size();
    line_buf.delete();
  endtask

  // Random sentence. Mostly well-formed with random body and digits; the rest
  // covers wrong sums, bad digits, cut-off tails, stray '*' and newline in the
  // body, a missing '$' and plain noise. A few run past the 127-byte count.
  task automatic compose_sentence();
    int               kind;
    int               len;
    int               cut;
    int               pos;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] c;
    bit               closed;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) len = $urandom_range(118, 135);
    else len = $urandom_range(0, 28);
    if (kind < 95) begin
      if (kind >= 88 && $urandom_range(0, 1) == 1)
        line_buf.insert(line_buf.size(), body_char());
      else line_buf.insert(line_buf.size(), ChDollar);
      sum = '0;
      closed = 1'b0;
      for (int i = 0; i < len; i++) begin
        if (kind >= 80 && $urandom_range(0, 7) == 0)
          c = $urandom_range(0, 1) ? ChStar : ChNl;
        else
          c = body_char();
        if (c == ChStar || c == ChNl) closed = 1'b1;
        else if (!closed) sum ^= c;
        line_buf.insert(line_buf.size(), c);
      end
      line_buf.insert(line_buf.size(), ChStar);
      if (kind >= 60 && kind < 70) sum ^= 8'($urandom_range(1, 255));
      line_buf.insert(line_buf.size(), hex_char(sum[7:4], $urandom_range(0, 1)));
      line_buf.insert(line_buf.size(), hex_char(sum[3:0], $urandom_range(0, 1)));
      if (kind >= 70 && kind < 75) begin
        pos = line_buf.size() - 1 - $urandom_range(0, 1);
        line_buf[pos] = 8'($urandom);
      end
      // Trailing CR/LF leaves both sums alone but counts toward the length.
      if ($urandom_range(0, 1) == 1) begin
        line_buf.insert(line_buf.size(), 8'h0D);
        line_buf.insert(line_buf.size(), ChNl);
      end
      if (kind >= 75 && kind < 88) begin
        cut = $urandom_range(1, line_buf.size());
        while (line_buf.size() > cut) void'(line_buf.pop_back());
      end
    end else begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 5) == 0) line_buf.insert(line_buf.size(), ChStar);
        else line_buf.insert(line_buf.size(), 8'($urandom));
      end
    end
    queue_line();
  endtask

  // Driver: presents queued character requests, with a random gap after each unless in_calm is set.
  // Accepted requests go straight into the predictor.
  always @(posedge clk) begin
    if (rst) begin
      char_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (char_if.valid && char_if.ready) begin
        fold_char(char_if.data_byte, char_if.last_byte);
        in_gap = in_calm ? 0 : $urandom_range(0, 12);
      end
      if (!char_if.valid || char_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          char_if.valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          cur_req = char_q.pop_front();
          char_if.valid <= 1'b1;
          char_if.data_byte <= cur_req.ch;
          char_if.last_byte <= cur_req.is_last;
        end else begin
          char_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes reports with random stalls, none when out_calm is set, and checks
  // each one against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      report_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (report_if.valid && report_if.ready) begin
        if (report_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected report: status %0d computed %02h received %02h",
                     report_if.status, report_if.computed_sum, report_if.received_sum);
          fail_count++;
        end else begin
          want = report_q.pop_front();
          if (report_if.status !== want.status ||
              report_if.computed_sum !== want.computed_sum ||
              report_if.received_sum !== want.received_sum) begin
            if (fail_count < 10)
              $display("report mismatch: expected status %0d computed %02h received %02h, %s",
                       want.status, want.computed_sum, want.received_sum,
                       $sformatf("got status %0d computed %02h received %02h",
                                 report_if.status, report_if.computed_sum,
                                 report_if.received_sum));
            fail_count++;
          end
        end
        out_gap = out_calm ? 0 : $urandom_range(0, 12);
      end
      if (out_gap > 0) begin
        out_gap--;
        report_if.ready <= 1'b0;
      end else begin
        report_if.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, a short directed set, then random phases, each under
  // its own register setting and each started from an idle block.
  initial begin
    logic [LenW-1:0] min_v;
    logic [LenW-1:0] max_v;
    int              budget;
    int              start;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    char_if.valid = 1'b0;
    char_if.data_byte = '0;
    char_if.last_byte = 1'b0;
    report_if.ready = 1'b0;
    fail_count = 0;
    bytes_sent = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    cfg_min_len = MinLenRst;
    cfg_max_len = MaxLenRst;
    len_cnt = '0;
    body_xor = '0;
    body_closed = 1'b0;
    lead_dollar = 1'b0;
    star_open = 1'b0;
    digits_got = 2'd0;
    digit_hi = '0;
    digit_lo = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the widest length window so short lines get through.
    write_reg(RegMinLength, 7'd1);
    write_reg(RegMaxLength, LenSat);
    @(negedge clk);
    add_text("$*00");                   // empty body, good sum
    queue_line();
    add_text("*");                      // star as first byte: no '$'
    queue_line();
    line_buf.insert(line_buf.size(), ChDollar);  // extreme bytes as data, lowercase digits
    line_buf.insert(line_buf.size(), 8'hFF);
    line_buf.insert(line_buf.size(), 8'h00);
    add_text("*ff");
    queue_line();
    add_text("$A*4g");                  // non-hex digit
    queue_line();
    add_text("$A*4");                   // one digit only
    queue_line();
    add_text("$A");                     // no star at all
    queue_line();
    add_text("$a");                     // newline ends the XOR early
    line_buf.insert(line_buf.size(), ChNl);
    add_text("b*61");
    queue_line();

    for (int p = 0; p < Phases; p++) begin
      wait_idle();
      case (p)
        0: begin min_v = 7'd9;   max_v = 7'd82;  end
        1: begin min_v = 7'd0;   max_v = 7'd127; end
        2: begin min_v = 7'd20;  max_v = 7'd30;  end
        3: begin min_v = 7'd127; max_v = 7'd127; end
        4: begin min_v = 7'd40;  max_v = 7'd10;  end  // min above max
        5: begin min_v = 7'd0;   max_v = 7'd0;   end
        6: begin min_v = 7'd5;   max_v = 7'd0;   end
        7: begin min_v = 7'd1;   max_v = 7'd1;   end
        default: begin min_v = MinLenRst; max_v = MaxLenRst; end
      endcase
      if (p == Phases - 1) write_reg(RegSpare, 7'($urandom));
      write_reg(RegMinLength, min_v);
      write_reg(RegMaxLength, max_v);
      // Some phases run one side or both with no idling at all.
      in_calm = (p % 3 == 2);
      out_calm = (p % 4 == 1);
      budget = (p == 0 || p == Phases - 1) ? 400 : 130;
      @(negedge clk);
      start = bytes_sent;
      while (bytes_sent - start < budget) compose_sentence();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (report_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/nmv_pkg.sv
hdl/nmv_in_if.sv
hdl/nmv_out_if.sv
hdl/nmv_track.sv
hdl/nmea_sentence_validator.sv
bench/tb_nmea_sentence_validator.sv
